// ===== rtl/core/sked_pkg.sv =====
package sked_pkg;

    // Default configuration of the decoder
    localparam int EXT_BASE_DEF   = 96;
    localparam int RING_DEPTH_DEF = 256;

    // Number of keys per bank (plain or extended)
    localparam int KEY_SPAN = 96;

    // Depth of the command queue between front and back
    localparam int Q_DEPTH = 4;

    // Scancode set-1 constants
    localparam logic [7:0] C_BREAK_BIT  = 8'h80;
    localparam logic [6:0] C_KEY_MASK   = 7'h7F;
    localparam logic [7:0] C_PFX_EXT    = 8'hE0;
    localparam logic [7:0] C_PFX_PAUSE  = 8'hE1;
    localparam logic [7:0] C_PFX_SKIP   = 8'hE2;
    localparam logic [6:0] C_KEY_LIMIT  = 7'h60;

    // Command handed from the front to the back
    typedef struct packed {
        logic       is_pop;
        logic       down;
        logic [7:0] code;
    } t_cmd;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/core/sked_if.sv =====
interface sked_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] raw_byte;

    modport source (output valid, output func, output raw_byte, input ready);
    modport sink   (input valid, input func, input raw_byte, output ready);
endinterface

interface sked_out_if;
    logic       valid;
    logic       ready;
    logic       event_valid;
    logic       key_down;
    logic [7:0] key_code;

    modport source (output valid, output event_valid, output key_down, output key_code,
                    input ready);
    modport sink   (input valid, input event_valid, input key_down, input key_code,
                    output ready);
endinterface

// ===== rtl/core/sked_front.sv =====
module sked_front
    import sked_pkg::*;
#(
    parameter int EXT_BASE = EXT_BASE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sked_in_if.sink     i_in,
    input  logic        i_q_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    localparam int TBL   = EXT_BASE + KEY_SPAN;
    localparam int IDX_W = $clog2(TBL);

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_EXT,
        PFX_SKIP
    } t_prefix;

    t_prefix          r_prefix, n_prefix;
    logic [TBL-1:0]   r_table, n_table;

    logic             fire;
    logic             is_byte;
    logic [6:0]       key;
    logic             down;
    logic             note;
    logic [7:0]       ev_code;
    logic [IDX_W-1:0] tbl_idx;
    logic             changed;

    // Accept whenever the queue has room
    assign i_in.ready = !i_q_full;
    assign fire       = i_in.valid && i_in.ready;
    assign is_byte    = fire && !i_in.func;

    assign key  = i_in.raw_byte[6:0] & C_KEY_MASK;
    assign down = (i_in.raw_byte & C_BREAK_BIT) == 8'h00;

    // Classify the byte against the pending prefix
    always_comb begin
        n_prefix = r_prefix;
        note     = 1'b0;
        ev_code  = {1'b0, key};
        case (r_prefix)
            PFX_EXT: begin
                note     = key < C_KEY_LIMIT;
                ev_code  = {1'b0, key} + 8'(EXT_BASE);
                n_prefix = PFX_NONE;
            end
            PFX_SKIP: begin
                n_prefix = PFX_NONE;
            end
            PFX_NONE: begin
                if (i_in.raw_byte == C_PFX_EXT) begin
                    n_prefix = PFX_EXT;
                end else if (i_in.raw_byte == C_PFX_PAUSE || i_in.raw_byte == C_PFX_SKIP) begin
                    n_prefix = PFX_SKIP;
                end else begin
                    note = key < C_KEY_LIMIT;
                end
            end
            default: begin
                n_prefix = PFX_NONE;
            end
        endcase
    end

    // Look up the pressed state and note only changes
    assign tbl_idx = ev_code[IDX_W-1:0];
    assign changed = note && (r_table[tbl_idx] != down);

    always_comb begin
        n_table = r_table;
        if (is_byte && changed) begin
            n_table[tbl_idx] = down;
        end
    end

    // Hand pops and key changes to the back
    assign o_push      = fire && (i_in.func || changed);
    assign o_cmd.is_pop = i_in.func;
    assign o_cmd.down   = down;
    assign o_cmd.code   = ev_code;

    // Hold prefix state and pressed table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= PFX_NONE;
            r_table  <= '0;
        end else begin
            if (is_byte) begin
                r_prefix <= n_prefix;
            end
            r_table <= n_table;
        end
    end

endmodule

// ===== rtl/core/sked_cmd_queue.sv =====
module sked_cmd_queue
    import sked_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_q_stat o_stat,
    output t_cmd    o_cmd
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_slot [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_stat.full  = r_count == CNT_W'(Q_DEPTH);
    assign o_stat.empty = r_count == '0;
    assign o_cmd        = r_slot[r_rd_ptr];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    // Store the incoming command
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/sked_back.sv =====
module sked_back
    import sked_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_cmd        i_cmd,
    output logic        o_take,
    sked_out_if.source  o_out
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    logic [8:0]       r_ring [RING_DEPTH];
    logic [PTR_W-1:0] r_head, r_tail;
    logic [CNT_W-1:0] r_count;
    logic [8:0]       r_rd_data;
    logic             r_out_valid;
    logic             r_out_hit;

    logic out_free;
    logic take_push, take_pop;
    logic ring_empty, ring_full;
    logic do_write, do_read;

    assign out_free   = !r_out_valid || o_out.ready;
    assign o_take     = !i_q_empty && (!i_cmd.is_pop || out_free);
    assign take_push  = o_take && !i_cmd.is_pop;
    assign take_pop   = o_take && i_cmd.is_pop;
    assign ring_empty = r_count == '0;
    assign ring_full  = r_count == CNT_W'(RING_DEPTH);
    assign do_write   = take_push && !ring_full;
    assign do_read    = take_pop && !ring_empty;

    // Write events and read the oldest one
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_ring[r_tail] <= {i_cmd.down, i_cmd.code};
        end
        if (do_read) begin
            r_rd_data <= r_ring[r_head];
        end
        if (take_pop) begin
            r_out_hit <= !ring_empty;
        end
    end

    // Advance ring pointers, occupancy and the output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (do_write) begin
                r_tail  <= (r_tail == PTR_W'(RING_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                r_count <= r_count + 1'b1;
            end
            if (do_read) begin
                r_head  <= (r_head == PTR_W'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end
            if (take_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Drive the result, zeroed on an empty pop
    assign o_out.valid       = r_out_valid;
    assign o_out.event_valid = r_out_hit;
    assign o_out.key_down    = r_out_hit && r_rd_data[8];
    assign o_out.key_code    = r_out_hit ? r_rd_data[7:0] : 8'h00;

endmodule

// ===== rtl/core/scancode_key_event_decoder_unit.sv =====
// Keyboard scancode set-1 key event decoder.
// Input channel i_in: func = 0 carries a raw scancode byte, func = 1 asks
// for the oldest queued key event. Bytes give no result; each pop gives
// exactly one result on o_out (event_valid, key_down, key_code), with
// event_valid low and the other fields zero when no event is queued.
// Throughput: one transaction per cycle on i_in while o_out is not stalled,
// since the front classifies a byte combinationally and the back serves one
// command per cycle through the single port of the event ring.
// A pop's result passes through the command queue and then the registered
// output slot of the back, after any commands queued ahead of it.
// Reset: synchronous, active low; prefix, pressed table, ring pointers and
// queue clear together, with no clearing pass over the ring.
// Receiver stall: the result holds on o_out; the back halts at the next
// pop, the four-entry command queue fills and i_in.ready then drops.
// A full ring drops new events while the pressed table still follows keys.
module scancode_key_event_decoder_unit
    import sked_pkg::*;
#(
    parameter int EXT_BASE   = EXT_BASE_DEF,
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sked_in_if.sink     i_in,
    sked_out_if.source  o_out
);

    t_q_stat q_stat;
    t_cmd    push_cmd, head_cmd;
    logic    push, take;

    sked_front #(
        .EXT_BASE (EXT_BASE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_stat.full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    sked_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (take),
        .o_stat  (q_stat),
        .o_cmd   (head_cmd)
    );

    sked_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_stat.empty),
        .i_cmd     (head_cmd),
        .o_take    (take),
        .o_out     (o_out)
    );

endmodule

// ===== rtl/core/sked_checker.sv =====
module sked_checker
    import sked_pkg::*;
#(
    parameter int EXT_BASE = EXT_BASE_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_event_valid,
    input logic       i_key_down,
    input logic [7:0] i_key_code
);

    localparam int TBL = EXT_BASE + KEY_SPAN;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_event_valid) && $stable(i_key_down)
            && $stable(i_key_code))
        else $error("stalled result changed");

    // Zero the fields of an empty pop
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_event_valid |-> !i_key_down && i_key_code == 8'h00)
        else $error("empty pop carries key fields");

    // Keep reported codes inside the key table
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_valid |-> 32'(i_key_code) < TBL)
        else $error("key code beyond table");

    // Drop input ready only behind a stalled result
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> $past(i_out_valid && !i_out_ready))
        else $error("input stalled without output back-pressure");

endmodule

bind scancode_key_event_decoder_unit sked_checker #(
    .EXT_BASE (EXT_BASE)
) u_sked_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_event_valid (o_out.event_valid),
    .i_key_down    (o_out.key_down),
    .i_key_code    (o_out.key_code)
);
